FILE: design/rrwl_pkg.sv
package rrwl_pkg;

    // default sizes
    localparam int NUM_THREADS_DEF = 16;
    localparam int MAX_DEPTH_DEF   = 255;

    // fixed field widths
    localparam int OPCODE_W = 3;
    localparam int TID_IN_W = 4;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 8;

    // mode lock count saturates here
    localparam logic [OUT_W-1:0] LOCK_MAX = 8'd255;

    // request codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_GET_READ   = 3'd0,
        OP_GET_WRITE  = 3'd1,
        OP_RELEASE    = 3'd2,
        OP_MODE_LOCK  = 3'd3,
        OP_MODE_UNLK  = 3'd4,
        OP_CLEAR_MOD  = 3'd5,
        OP_QUERY      = 3'd6
    } opcode_t;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_RETRY  = 2'd1,
        ST_MISUSE = 2'd2
    } status_t;

    // one request
    typedef struct packed {
        logic                release_all;
        logic                upgrade_read_only;
        logic [TID_IN_W-1:0] thread_id;
        logic [OPCODE_W-1:0] opcode;
    } req_t;

    // one result
    typedef struct packed {
        logic [OUT_W-1:0]    lock_count;
        logic                mode_locked;
        logic                was_modified;
        logic                holds_read_write;
        logic                holds_read_only;
        logic [OUT_W-1:0]    depth;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // global lock state seen from outside the core
    typedef struct packed {
        logic writer_held;
        logic readers_present;
    } lock_state_t;

endpackage

FILE: design/rrwl_core.sv
module rrwl_core #(
    parameter int NUM_THREADS = rrwl_pkg::NUM_THREADS_DEF,
    parameter int MAX_DEPTH   = rrwl_pkg::MAX_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  rrwl_pkg::req_t        req,
    input  logic                  control_disabled,
    output rrwl_pkg::rsp_t        rsp,
    output rrwl_pkg::lock_state_t lock_state
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int TID_W   = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int RDR_W   = $clog2(NUM_THREADS + 1);
    localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_DEPTH);

    // per-thread table: depth magnitude, write flag, switch depth
    logic [DEPTH_W-1:0]     mag_reg [NUM_THREADS];
    logic [NUM_THREADS-1:0] wr_reg;
    logic [DEPTH_W-1:0]     sw_reg  [NUM_THREADS];
    logic [NUM_THREADS-1:0] mod_reg;
    logic [RDR_W-1:0]       rdr_reg;
    logic                   wtr_reg;
    logic [rrwl_pkg::OUT_W-1:0] lock_reg;

    logic [DEPTH_W-1:0]     mag_next;
    logic                   wr_next;
    logic [DEPTH_W-1:0]     sw_next;
    logic [NUM_THREADS-1:0] mod_next;
    logic [RDR_W-1:0]       rdr_next;
    logic                   wtr_next;
    logic [rrwl_pkg::OUT_W-1:0] lock_next;

    logic [TID_W+rrwl_pkg::TID_IN_W-1:0] tid_wide;
    logic [TID_W-1:0]       idx;
    logic                   in_range;
    logic [DEPTH_W-1:0]     m;
    logic                   w;
    logic [DEPTH_W-1:0]     sw;
    logic                   ro;
    logic                   rw;
    logic                   at_max;
    logic [DEPTH_W-1:0]     dropped;
    rrwl_pkg::status_t      st;
    logic [DEPTH_W+rrwl_pkg::OUT_W-1:0] mag_wide;

    // entry select
    assign tid_wide = {{TID_W{1'b0}}, req.thread_id};
    assign idx      = tid_wide[TID_W-1:0];
    assign in_range = 32'(req.thread_id) < NUM_THREADS;
    assign m        = mag_reg[idx];
    assign w        = wr_reg[idx];
    assign sw       = sw_reg[idx];
    assign ro       = (m != '0) && !w;
    assign rw       = (m != '0) && w;
    assign at_max   = m >= MAX_D;
    assign dropped  = req.release_all ? '0 : m - 1'b1;

    // request decode and next state
    always_comb
    begin
        st        = rrwl_pkg::ST_OK;
        mag_next  = m;
        wr_next   = w;
        sw_next   = sw;
        mod_next  = mod_reg;
        rdr_next  = rdr_reg;
        wtr_next  = wtr_reg;
        lock_next = lock_reg;
        case (req.opcode)
            rrwl_pkg::OP_GET_READ:
            begin
                if (rw)
                begin
                    if (at_max) st = rrwl_pkg::ST_MISUSE;
                    else mag_next = m + 1'b1;
                end
                else if (wtr_reg) st = rrwl_pkg::ST_RETRY;
                else if (m == '0)
                begin
                    rdr_next = rdr_reg + 1'b1;
                    mag_next = DEPTH_W'(1);
                    wr_next  = 1'b0;
                end
                else if (at_max) st = rrwl_pkg::ST_MISUSE;
                else mag_next = m + 1'b1;
            end
            rrwl_pkg::OP_GET_WRITE:
            begin
                if (ro)
                begin
                    if (!req.upgrade_read_only) st = rrwl_pkg::ST_MISUSE;
                    else if (rdr_reg != RDR_W'(1) || wtr_reg) st = rrwl_pkg::ST_RETRY;
                    else if (at_max) st = rrwl_pkg::ST_MISUSE;
                    else
                    begin
                        sw_next  = m;
                        rdr_next = '0;
                        wtr_next = 1'b1;
                        mag_next = m + 1'b1;
                        wr_next  = 1'b1;
                    end
                end
                else if (rw)
                begin
                    if (at_max) st = rrwl_pkg::ST_MISUSE;
                    else mag_next = m + 1'b1;
                end
                else if (rdr_reg != '0 || wtr_reg) st = rrwl_pkg::ST_RETRY;
                else
                begin
                    wtr_next = 1'b1;
                    mag_next = DEPTH_W'(1);
                    wr_next  = 1'b1;
                end
            end
            rrwl_pkg::OP_RELEASE:
            begin
                if (m == '0) st = rrwl_pkg::ST_MISUSE;
                else if (w)
                begin
                    mag_next = dropped;
                    if (dropped == '0)
                    begin
                        wtr_next = 1'b0;
                        mod_next = '1;
                    end
                    else if (dropped == sw)
                    begin
                        // write levels fall back to read-only at the switch depth
                        wtr_next = 1'b0;
                        mod_next = '1;
                        rdr_next = rdr_reg + 1'b1;
                        wr_next  = 1'b0;
                        sw_next  = '0;
                    end
                end
                else
                begin
                    mag_next = dropped;
                    if (dropped == '0 && rdr_reg != '0) rdr_next = rdr_reg - 1'b1;
                end
                if (mag_next == '0)
                begin
                    sw_next = '0;
                    wr_next = 1'b0;
                end
            end
            rrwl_pkg::OP_MODE_LOCK:
            begin
                if (m == '0) st = rrwl_pkg::ST_MISUSE;
                else if (wtr_reg && !rw) st = rrwl_pkg::ST_RETRY;
                else if (lock_reg >= rrwl_pkg::LOCK_MAX) st = rrwl_pkg::ST_MISUSE;
                else lock_next = lock_reg + 1'b1;
            end
            rrwl_pkg::OP_MODE_UNLK:
            begin
                if (lock_reg == '0) st = rrwl_pkg::ST_MISUSE;
                else lock_next = lock_reg - 1'b1;
            end
            rrwl_pkg::OP_CLEAR_MOD:
            begin
                mod_next[idx] = 1'b0;
            end
            rrwl_pkg::OP_QUERY:
            begin
                st = rrwl_pkg::ST_OK;
            end
            default:
            begin
                st = rrwl_pkg::ST_MISUSE;
            end
        endcase
    end

    // state update, one entry per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                mag_reg[i] <= '0;
                sw_reg[i]  <= '0;
            end
            wr_reg   <= '0;
            mod_reg  <= '0;
            rdr_reg  <= '0;
            wtr_reg  <= 1'b0;
            lock_reg <= '0;
        end
        else if (go && in_range)
        begin
            mag_reg[idx] <= mag_next;
            wr_reg[idx]  <= wr_next;
            sw_reg[idx]  <= sw_next;
            mod_reg      <= mod_next;
            rdr_reg      <= rdr_next;
            wtr_reg      <= wtr_next;
            lock_reg     <= lock_next;
        end
    end

    // result fields
    assign mag_wide = {{rrwl_pkg::OUT_W{1'b0}}, mag_next};

    always_comb
    begin
        rsp.lock_count  = in_range ? lock_next : lock_reg;
        rsp.mode_locked = rsp.lock_count != '0;
        if (in_range)
        begin
            rsp.status           = st;
            rsp.depth            = mag_wide[rrwl_pkg::OUT_W-1:0];
            rsp.holds_read_only  = (mag_next != '0) && !wr_next && !control_disabled;
            rsp.holds_read_write = ((mag_next != '0) && wr_next) || control_disabled;
            rsp.was_modified     = mod_next[idx];
        end
        else
        begin
            rsp.status           = rrwl_pkg::ST_MISUSE;
            rsp.depth            = '0;
            rsp.holds_read_only  = 1'b0;
            rsp.holds_read_write = control_disabled;
            rsp.was_modified     = 1'b0;
        end
    end

    assign lock_state.writer_held     = wtr_reg;
    assign lock_state.readers_present = rdr_reg != '0;

endmodule

FILE: design/reentrant_reader_writer_lock_unit.sv
// Reentrant reader/writer lock unit. Each transfer on the s_ side is one request from one
// thread (get read, get read-write with optional upgrade, release one or all levels, mode
// lock and unlock, clear modified, query); each request yields exactly one result on the
// m_ side with a status (done, retry, misuse) and the thread's view of the lock after the
// request. Requests that would block in software come back as retry with no state change.
// The unit takes one request every cycle while the m_ side is not stalled. A request is held
// in the input register while the thread table is read, updated and written back; its result
// is then registered in the result register and offered on the m_ side. A stalled m_ side
// holds the result and backs up through the input register. The control_disabled register
// resets to 1; the user must write it through cfg_valid/cfg_data only while no request is
// in flight, and the block itself does not enforce this.
module reentrant_reader_writer_lock_unit #(
    parameter int NUM_THREADS = rrwl_pkg::NUM_THREADS_DEF,
    parameter int MAX_DEPTH   = rrwl_pkg::MAX_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], thread_id[6:3], upgrade_read_only[7], release_all[8], zero fill
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], depth[9:2], holds_read_only[10], holds_read_write[11],
    // was_modified[12], mode_locked[13], lock_count[21:14], zero fill
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int REQ_W = $bits(rrwl_pkg::req_t);
    localparam int RSP_W = $bits(rrwl_pkg::rsp_t);

    logic                  in_valid_reg;
    rrwl_pkg::req_t        req_reg;
    logic                  out_valid_reg;
    rrwl_pkg::rsp_t        rsp_reg;
    logic                  ctl_dis_reg;
    logic                  advance;
    logic                  go;
    rrwl_pkg::rsp_t        rsp;
    rrwl_pkg::lock_state_t lock_state;

    // handshake
    assign advance   = !out_valid_reg || m_tready;
    assign go        = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(24 - RSP_W){1'b0}}, rsp_reg};
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_dis_reg <= 1'b1;
        else if (cfg_valid)
            ctl_dis_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            req_reg <= s_tdata[REQ_W-1:0];
    end

    // lock table and request logic
    rrwl_core #(
        .NUM_THREADS(NUM_THREADS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .go              (go),
        .req             (req_reg),
        .control_disabled(ctl_dis_reg),
        .rsp             (rsp),
        .lock_state      (lock_state)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (go)
            rsp_reg <= rsp;
    end

    // a writer never coexists with readers
    assert property (@(posedge clk) disable iff (!rst_n)
        !(lock_state.writer_held && lock_state.readers_present))
        else $error("writer held while readers present");

    // mode lock flag agrees with the count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (rsp_reg.mode_locked == (rsp_reg.lock_count != '0)))
        else $error("mode_locked disagrees with lock_count");

    // read-only and read-write are never reported together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(rsp_reg.holds_read_only && rsp_reg.holds_read_write))
        else $error("both read-only and read-write reported");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int THREADS   = rrwl_pkg::NUM_THREADS_DEF;
    localparam int DEPTH_MAX = rrwl_pkg::MAX_DEPTH_DEF;
    localparam int LOCK_TOP  = 255;

    // the one opcode the package leaves undefined
    localparam logic [rrwl_pkg::OPCODE_W-1:0] OP_ILLEGAL = 3'd7;

    // per-thread nesting, global lock counters and the results they imply
    class lock_scoreboard;
        int               nest [THREADS];
        int               switch_at [THREADS];
        logic [THREADS-1:0] modified;
        int               readers;
        bit               writer;
        int               lock_total;
        bit               ctrl_off;
        rrwl_pkg::rsp_t   pending [$];
        int               errors;
        int               checked;
        int               noted;

        function new();
            ctrl_off = 1'b1;
            modified = '0;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch on result %0d: %s", $time, checked, what);
        endtask

        // remove write levels, one or down to zero
        function void drop_write(int t, bit every);
            do
                nest[t]--;
            while (every && nest[t] > 0);
            if (nest[t] == 0)
            begin
                writer   = 1'b0;
                modified = '1;
            end
        endfunction

        // advance the lock state by one accepted request
        function void note_request(rrwl_pkg::req_t r);
            int                t;
            int                m;
            int                sw;
            int                mag;
            rrwl_pkg::status_t st;
            rrwl_pkg::rsp_t    e;
            t  = r.thread_id;
            m  = nest[t];
            st = rrwl_pkg::ST_OK;
            case (r.opcode)
                rrwl_pkg::OP_GET_READ:
                    if (m > 0)
                    begin
                        if (m >= DEPTH_MAX) st = rrwl_pkg::ST_MISUSE;
                        else nest[t] = m + 1;
                    end
                    else if (writer) st = rrwl_pkg::ST_RETRY;
                    else if (m == 0)
                    begin
                        readers++;
                        nest[t] = -1;
                    end
                    else if (-m >= DEPTH_MAX) st = rrwl_pkg::ST_MISUSE;
                    else nest[t] = m - 1;
                rrwl_pkg::OP_GET_WRITE:
                    if (m < 0)
                    begin
                        if (!r.upgrade_read_only) st = rrwl_pkg::ST_MISUSE;
                        else if (readers != 1 || writer) st = rrwl_pkg::ST_RETRY;
                        else if (-m >= DEPTH_MAX) st = rrwl_pkg::ST_MISUSE;
                        else
                        begin
                            switch_at[t] = -m;
                            readers      = 0;
                            writer       = 1'b1;
                            nest[t]      = -m + 1;
                        end
                    end
                    else if (m > 0)
                    begin
                        if (m >= DEPTH_MAX) st = rrwl_pkg::ST_MISUSE;
                        else nest[t] = m + 1;
                    end
                    else if (readers > 0 || writer) st = rrwl_pkg::ST_RETRY;
                    else
                    begin
                        writer  = 1'b1;
                        nest[t] = 1;
                    end
                rrwl_pkg::OP_RELEASE:
                begin
                    if (m == 0) st = rrwl_pkg::ST_MISUSE;
                    else if (m > 0)
                    begin
                        drop_write(t, r.release_all);
                        sw = switch_at[t];
                        // back at the upgrade depth: write turns into read-only
                        if (nest[t] > 0 && nest[t] == sw)
                        begin
                            drop_write(t, 1'b1);
                            readers++;
                            nest[t]      = -sw;
                            switch_at[t] = 0;
                        end
                    end
                    else
                    begin
                        nest[t] = r.release_all ? 0 : m + 1;
                        if (nest[t] == 0 && readers > 0) readers--;
                    end
                    if (nest[t] == 0) switch_at[t] = 0;
                end
                rrwl_pkg::OP_MODE_LOCK:
                    if (m == 0) st = rrwl_pkg::ST_MISUSE;
                    else if (writer && m <= 0) st = rrwl_pkg::ST_RETRY;
                    else if (lock_total >= LOCK_TOP) st = rrwl_pkg::ST_MISUSE;
                    else lock_total++;
                rrwl_pkg::OP_MODE_UNLK:
                    if (lock_total == 0) st = rrwl_pkg::ST_MISUSE;
                    else lock_total--;
                rrwl_pkg::OP_CLEAR_MOD: modified[t] = 1'b0;
                rrwl_pkg::OP_QUERY: ;
                default: st = rrwl_pkg::ST_MISUSE;
            endcase
            m   = nest[t];
            mag = (m < 0) ? -m : m;
            e.status           = st;
            e.depth            = mag[7:0];
            e.holds_read_only  = (m < 0) && !ctrl_off;
            e.holds_read_write = (m > 0) || ctrl_off;
            e.was_modified     = modified[t];
            e.mode_locked      = lock_total > 0;
            e.lock_count       = lock_total[7:0];
            pending.push_back(e);
            noted++;
        endfunction

        // compare one result transfer with the oldest expectation
        task check_result(rrwl_pkg::rsp_t got);
            rrwl_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("result %h with no request waiting", got));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status !== e.status)
                report($sformatf("status exp %0d got %0d", e.status, got.status));
            if (got.depth !== e.depth)
                report($sformatf("depth exp %0d got %0d", e.depth, got.depth));
            if (got.holds_read_only !== e.holds_read_only)
                report($sformatf("holds_read_only exp %0b got %0b",
                                 e.holds_read_only, got.holds_read_only));
            if (got.holds_read_write !== e.holds_read_write)
                report($sformatf("holds_read_write exp %0b got %0b",
                                 e.holds_read_write, got.holds_read_write));
            if (got.was_modified !== e.was_modified)
                report($sformatf("was_modified exp %0b got %0b",
                                 e.was_modified, got.was_modified));
            if (got.mode_locked !== e.mode_locked)
                report($sformatf("mode_locked exp %0b got %0b",
                                 e.mode_locked, got.mode_locked));
            if (got.lock_count !== e.lock_count)
                report($sformatf("lock_count exp %0d got %0d", e.lock_count, got.lock_count));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    lock_scoreboard sb;
    bit in_gaps     = 1'b1;
    bit out_stalls  = 1'b1;
    int stall_left  = 0;
    int stall_roll;
    int ctrl_writes = 0;

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    reentrant_reader_writer_lock_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // result side: check each transfer, stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(rrwl_pkg::rsp_t'(m_tdata[21:0]));
        if (!out_stalls)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_roll = $urandom_range(99);
            if (stall_roll < 15) stall_left = $urandom_range(1, 3);
            else if (stall_roll < 17) stall_left = $urandom_range(15, 40);
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (!in_gaps || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // random flag for request bits that the opcode ignores
    function automatic bit rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // one request transfer; valid stays up for a following request
    task automatic issue(input logic [rrwl_pkg::OPCODE_W-1:0] op, input int t,
                         input bit upg = 1'b0, input bit every = 1'b0);
        rrwl_pkg::req_t r;
        int             gap;
        r.opcode            = op;
        r.thread_id         = t[rrwl_pkg::TID_IN_W-1:0];
        r.upgrade_read_only = upg;
        r.release_all       = every;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(r);
    endtask

    // hold off requests until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write while the unit is idle
    task automatic write_control(input bit v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        sb.ctrl_off = v;
        ctrl_writes++;
    endtask

    // misuse corners, conflicts, upgrade and the switch back to read-only
    task automatic directed_requests();
        issue(rrwl_pkg::OP_QUERY, 0);
        issue(rrwl_pkg::OP_RELEASE, 0, 1'b0, 1'b1);
        issue(rrwl_pkg::OP_MODE_LOCK, 0);
        issue(rrwl_pkg::OP_MODE_UNLK, 0);
        issue(OP_ILLEGAL, 1, 1'b1, 1'b1);
        issue(rrwl_pkg::OP_GET_READ, 0);
        issue(rrwl_pkg::OP_GET_READ, 1);
        issue(rrwl_pkg::OP_GET_WRITE, 2, 1'b1);
        issue(rrwl_pkg::OP_GET_WRITE, 0);
        issue(rrwl_pkg::OP_GET_WRITE, 0, 1'b1);
        issue(rrwl_pkg::OP_RELEASE, 1);
        issue(rrwl_pkg::OP_MODE_LOCK, 0);
        issue(rrwl_pkg::OP_GET_READ, 0);
        issue(rrwl_pkg::OP_GET_WRITE, 0, 1'b1);
        issue(rrwl_pkg::OP_GET_READ, 0);
        issue(rrwl_pkg::OP_GET_READ, 1);
        issue(rrwl_pkg::OP_GET_WRITE, 15);
        issue(rrwl_pkg::OP_RELEASE, 0);
        issue(rrwl_pkg::OP_RELEASE, 0);
        issue(rrwl_pkg::OP_CLEAR_MOD, 0);
        issue(rrwl_pkg::OP_GET_WRITE, 0, 1'b1);
        issue(rrwl_pkg::OP_RELEASE, 0, 1'b0, 1'b1);
        issue(rrwl_pkg::OP_MODE_UNLK, 3);
        issue(rrwl_pkg::OP_GET_WRITE, 15, 1'b1, 1'b1);
        issue(rrwl_pkg::OP_RELEASE, 15, 1'b1, 1'b1);
    endtask

    // one thread climbs to full depth and full mode lock count, then overflows
    task automatic deep_nesting();
        int t;
        int roll;
        bit read_more;
        t = $urandom_range(THREADS - 1);
        issue(rrwl_pkg::OP_GET_READ, t);
        while (sb.nest[t] > -(DEPTH_MAX - 1) || sb.lock_total < LOCK_TOP - 1)
        begin
            roll = $urandom_range(99);
            read_more = sb.nest[t] > -(DEPTH_MAX - 1)
                        && (sb.lock_total >= LOCK_TOP - 1 || roll < 54);
            if (roll < 4)
                issue(rrwl_pkg::OP_QUERY, t, rand_bit(), rand_bit());
            else if (roll < 8)
                issue(rrwl_pkg::OP_CLEAR_MOD, t, rand_bit(), rand_bit());
            else if (read_more)
                issue(rrwl_pkg::OP_GET_READ, t, rand_bit(), rand_bit());
            else
                issue(rrwl_pkg::OP_MODE_LOCK, t, rand_bit(), rand_bit());
        end
        issue(rrwl_pkg::OP_GET_READ, t);
        issue(rrwl_pkg::OP_GET_READ, t);
        issue(rrwl_pkg::OP_GET_WRITE, t, 1'b1);
        issue(rrwl_pkg::OP_RELEASE, t);
        issue(rrwl_pkg::OP_GET_WRITE, t, 1'b1);
        issue(rrwl_pkg::OP_MODE_LOCK, t);
        issue(rrwl_pkg::OP_MODE_LOCK, t);
        issue(rrwl_pkg::OP_GET_READ, t);
        issue(rrwl_pkg::OP_GET_WRITE, t);
        issue(rrwl_pkg::OP_RELEASE, t);
        issue(rrwl_pkg::OP_QUERY, t);
        issue(rrwl_pkg::OP_RELEASE, t, 1'b0, 1'b1);
    endtask

    // random request, mostly from a small pool of threads so they collide
    task automatic random_request(input int p0, input int p1, input int p2);
        int                            roll;
        int                            t;
        logic [rrwl_pkg::OPCODE_W-1:0] op;
        bit                            upg;
        bit                            every;
        roll = $urandom_range(99);
        if (roll < 24) op = rrwl_pkg::OP_GET_READ;
        else if (roll < 44) op = rrwl_pkg::OP_GET_WRITE;
        else if (roll < 68) op = rrwl_pkg::OP_RELEASE;
        else if (roll < 76) op = rrwl_pkg::OP_MODE_LOCK;
        else if (roll < 84) op = rrwl_pkg::OP_MODE_UNLK;
        else if (roll < 91) op = rrwl_pkg::OP_CLEAR_MOD;
        else if (roll < 97) op = rrwl_pkg::OP_QUERY;
        else op = OP_ILLEGAL;
        roll = $urandom_range(99);
        if (roll < 28) t = p0;
        else if (roll < 56) t = p1;
        else if (roll < 85) t = p2;
        else t = $urandom_range(THREADS - 1);
        upg   = (op == rrwl_pkg::OP_GET_WRITE) ? ($urandom_range(9) < 7) : rand_bit();
        every = (op == rrwl_pkg::OP_RELEASE) ? ($urandom_range(9) < 3) : rand_bit();
        issue(op, t, upg, every);
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // main sequence
    initial
    begin
        int p0;
        int p1;
        int p2;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_control(1'b0);
        directed_requests();
        write_control(1'b1);
        deep_nesting();

        for (int seg = 0; seg < 4; seg++)
        begin
            write_control(seg[0]);
            // one segment with no idling on either side
            in_gaps    = (seg != 2);
            out_stalls = (seg != 2);
            p0 = $urandom_range(THREADS - 1);
            p1 = $urandom_range(THREADS - 1);
            p2 = $urandom_range(THREADS - 1);
            for (int i = 0; i < 115; i++)
            begin
                if (seg == 1 && i == 60) wait_drained();
                random_request(p0, p1, p2);
            end
        end
        in_gaps    = 1'b1;
        out_stalls = 1'b1;

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        $display("covered %0d requests under %0d control writes, nesting and mode lock to 255",
                 sb.noted, ctrl_writes);
        $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/rrwl_pkg.sv
design/rrwl_core.sv
design/reentrant_reader_writer_lock_unit.sv
verif/tb_top.sv
